// File: sv/fast9_pkg.sv
// ----------------------------------------------------------------------------
// FAST-9 corner detector package
// Shared sizes, register indexes, circle geometry and small helpers.
// ----------------------------------------------------------------------------
package fast9_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int CIRCLE_POINTS = 16;
    localparam int ARC_LEN       = 9;
    localparam int WIN           = 7;
    localparam int PIX_ROWS      = 7;
    localparam int SCORE_ROWS    = 4;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1;
    localparam int CFG_W  = 12;
    localparam int PIX_W  = 8;
    localparam int DIFF_W = PIX_W + 1;
    localparam int ENTRY_W = PIX_W + 1;
    localparam int OUT_W  = 11;

    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_THRESH   = 2'd2;
    localparam logic [1:0] CFG_SUPPRESS = 2'd3;

    localparam logic [CFG_W-1:0] RST_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_HEIGHT = CFG_W'(480);
    localparam logic [PIX_W-1:0] RST_THRESH = PIX_W'(20);

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic [ENTRY_W-1:0] t_entry;

    localparam int CIRCLE_ROW [CIRCLE_POINTS] = '{6, 6, 5, 4, 3, 2, 1, 0,
                                                   0, 0, 1, 2, 3, 4, 5, 6};
    localparam int CIRCLE_COL [CIRCLE_POINTS] = '{3, 4, 5, 6, 6, 6, 5, 4,
                                                   3, 2, 1, 0, 0, 0, 1, 2};

    function automatic logic [2:0] slot_add(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 4'd7) begin
            s = s - 4'd7;
        end
        return s[2:0];
    endfunction

    function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int hi);
        logic [CNT_W-1:0] r;
        if (v < CFG_W'(7)) begin
            r = CNT_W'(7);
        end else if (CNT_W'(v) > CNT_W'(hi)) begin
            r = CNT_W'(hi);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

// File: sv/fast9_corner_detector.sv
// ----------------------------------------------------------------------------
// FAST-9 corner detector
// Raster pixel stream in, FAST-9 corners with optional 3x3 suppression out.
// ----------------------------------------------------------------------------
// One pixel per clock while o_stall is low, set by each line RAM's single write port.
// Results pass the stage-1 registers, the window registers and the output register.
// A two-entry output buffer lets input continue while one result waits.
// Reset clears counters and valid flags, sets default config; line RAMs stay undefined.
module fast9_corner_detector
    import fast9_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel_value,
    input  logic             i_frame_start,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [OUT_W-1:0] o_corner_x,
    output logic [OUT_W-1:0] o_corner_y,
    output logic [PIX_W-1:0] o_corner_score
);

    logic [CFG_W-1:0] r_width, r_height;
    logic [PIX_W-1:0] r_thresh;
    logic             r_suppress;
    logic [CNT_W-1:0] w, h;

    logic [CNT_W-1:0] r_col, r_row;
    logic [2:0]       r_row7;
    logic             r_drain;

    logic             en, accept;
    logic [CNT_W-1:0] c0, r0, c1, r1, y0;
    logic [2:0]       m0, m1;
    logic             d0, d1, eval0, dec0;

    logic             r_s1_valid, r_s1_eval, r_s1_dec;
    t_pix             r_s1_pix;
    logic [2:0]       r_s1_slot;
    logic [CNT_W-1:0] r_s1_x, r_s1_y, r_s1_r;

    logic             r_s2_valid, r_s2_eval, r_s2_dec;
    logic [CNT_W-1:0] r_s2_x, r_s2_y, r_s2_r;

    logic             r_s3_valid, r_s3_eval;
    logic [CNT_W-1:0] r_s3_x, r_s3_r;

    t_pix   pix_rd [PIX_ROWS];
    t_entry sc_rd [SCORE_ROWS];
    t_pix   r_win [WIN][WIN];
    t_entry r_dwin [3][3];
    t_pix   new_col [WIN];
    t_entry new_dcol [3];

    t_diff  dval [CIRCLE_POINTS];
    t_diff  arc_min [CIRCLE_POINTS];
    t_diff  arc_max [CIRCLE_POINTS];
    t_diff  r_arc_min [CIRCLE_POINTS];
    t_diff  r_arc_max [CIRCLE_POINTS];
    t_diff  tmax [CIRCLE_POINTS];
    t_diff  tmin [CIRCLE_POINTS];

    logic signed [DIFF_W:0] a_top, b_neg, best, thr;
    logic             corner;
    t_entry           entry;
    logic [1:0]       wr_slot;
    logic [COL_W-1:0] wr_addr;

    logic             res_valid, keep;
    logic [PIX_W-1:0] res_score;

    logic             r_out_valid, r_skid_valid;
    logic [OUT_W-1:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic [PIX_W-1:0] r_out_score, r_skid_score;
    logic             taken;

    assign w = clamp_size(r_width, MAX_WIDTH);
    assign h = clamp_size(r_height, MAX_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_thresh   <= RST_THRESH;
            r_suppress <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WIDTH:    r_width    <= i_cfg_data;
                CFG_HEIGHT:   r_height   <= i_cfg_data;
                CFG_THRESH:   r_thresh   <= i_cfg_data[PIX_W-1:0];
                CFG_SUPPRESS: r_suppress <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en     = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign accept = i_valid && en;

    always_comb begin
        if (i_frame_start) begin
            c0 = '0;
            r0 = '0;
            m0 = '0;
            d0 = (r_col != '0 || r_row != '0) ? 1'b0 : r_drain;
        end else begin
            c0 = r_col;
            r0 = r_row;
            m0 = r_row7;
            d0 = r_drain;
            if (c0 >= w) begin
                c0 = '0;
                r0 = r0 + 1'b1;
                m0 = slot_add(m0, 3'd1);
            end
            if (r0 >= h) begin
                r0 = '0;
                m0 = '0;
            end
        end
        c1 = c0 + 1'b1;
        r1 = r0;
        m1 = m0;
        d1 = d0;
        if (c1 >= w) begin
            c1 = '0;
            r1 = r0 + 1'b1;
            m1 = slot_add(m0, 3'd1);
            if (r1 >= h) begin
                r1 = '0;
                m1 = '0;
                d1 = 1'b1;
            end else if (r1 == CNT_W'(2)) begin
                d1 = 1'b0;
            end
        end
        eval0 = (r0 >= CNT_W'(6)) && (c0 >= CNT_W'(6)) && (c1 <= w);
        if (r0 >= CNT_W'(8)) begin
            y0   = r0 - CNT_W'(5);
            dec0 = 1'b1;
        end else begin
            y0   = h - CNT_W'(5) + r0;
            dec0 = d0 && (r0 <= CNT_W'(1));
        end
        dec0 = dec0 && (y0 >= CNT_W'(3)) && (y0 <= h - CNT_W'(4))
                    && (c0 >= CNT_W'(3)) && (c0 <= w - CNT_W'(4));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_row7  <= '0;
            r_drain <= 1'b0;
        end else if (accept) begin
            r_col   <= c1;
            r_row   <= r1;
            r_row7  <= m1;
            r_drain <= d1;
        end
    end

    for (genvar g = 0; g < PIX_ROWS; g++) begin : g_pix_ram
        fast9_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_pix_ram (
            .i_clk     (i_clk),
            .i_wr_en   (accept && (m0 == 3'(g))),
            .i_wr_addr (c0[COL_W-1:0]),
            .i_wr_data (i_pixel_value),
            .i_rd_en   (accept),
            .i_rd_addr (c0[COL_W-1:0]),
            .o_rd_data (pix_rd[g])
        );
    end

    assign wr_slot = r_s3_r[1:0] - 2'd3;
    assign wr_addr = r_s3_x[COL_W-1:0] - COL_W'(3);

    for (genvar g = 0; g < SCORE_ROWS; g++) begin : g_score_ram
        fast9_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WIDTH)) u_score_ram (
            .i_clk     (i_clk),
            .i_wr_en   (r_s3_valid && r_s3_eval && (wr_slot == 2'(g))),
            .i_wr_addr (wr_addr),
            .i_wr_data (entry),
            .i_rd_en   (accept),
            .i_rd_addr (c1[COL_W-1:0] + (c1 == '0 ? COL_W'(c0 + 1'b1) : COL_W'(0))
                        - (c1 == '0 ? COL_W'(0) : COL_W'(0))),
            .o_rd_data (sc_rd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_eval <= eval0;
            r_s1_dec  <= dec0;
            r_s1_pix  <= i_pixel_value;
            r_s1_slot <= m0;
            r_s1_x    <= c0;
            r_s1_y    <= y0;
            r_s1_r    <= r0;
            r_s2_eval <= r_s1_eval;
            r_s2_dec  <= r_s1_dec;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_r    <= r_s1_r;
            r_s3_eval <= r_s2_eval;
            r_s3_x    <= r_s2_x;
            r_s3_r    <= r_s2_r;
            r_arc_min <= arc_min;
            r_arc_max <= arc_max;
        end
    end

    always_comb begin
        logic [CNT_W-1:0] xx, yy;
        logic [1:0]       ys;
        logic             xin, yin;
        for (int i = 0; i < WIN - 1; i++) begin
            new_col[i] = pix_rd[slot_add(r_s1_slot, 3'(i + 1))];
        end
        new_col[WIN-1] = r_s1_pix;
        xx  = r_s1_x + 1'b1;
        xin = (xx >= CNT_W'(3)) && (xx <= w - CNT_W'(4));
        for (int i = 0; i < 3; i++) begin
            yy  = r_s1_y + CNT_W'(i) - 1'b1;
            ys  = r_s1_y[1:0] + 2'(i) - 2'd1;
            yin = (yy >= CNT_W'(3)) && (yy <= h - CNT_W'(4));
            new_dcol[i] = (xin && yin) ? sc_rd[ys] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_valid) begin
            for (int i = 0; i < WIN; i++) begin
                for (int j = 0; j < WIN - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][WIN-1] <= new_col[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_dwin[i][0] <= r_dwin[i][1];
                r_dwin[i][1] <= r_dwin[i][2];
                r_dwin[i][2] <= new_dcol[i];
            end
        end
    end

    always_comb begin
        t_diff mn, mx;
        for (int k = 0; k < CIRCLE_POINTS; k++) begin
            dval[k] = t_diff'({1'b0, r_win[3][3]} - {1'b0, r_win[CIRCLE_ROW[k]][CIRCLE_COL[k]]});
        end
        for (int k = 0; k < CIRCLE_POINTS; k++) begin
            mn = dval[k];
            mx = dval[k];
            for (int n = 1; n < ARC_LEN; n++) begin
                if (dval[4'(k + n)] < mn) begin
                    mn = dval[4'(k + n)];
                end
                if (dval[4'(k + n)] > mx) begin
                    mx = dval[4'(k + n)];
                end
            end
            arc_min[k] = mn;
            arc_max[k] = mx;
        end
    end

    always_comb begin
        tmax = r_arc_min;
        tmin = r_arc_max;
        for (int lev = 0; lev < 4; lev++) begin
            for (int i = 0; i < (CIRCLE_POINTS >> (lev + 1)); i++) begin
                tmax[i] = (tmax[2*i] > tmax[2*i+1]) ? tmax[2*i] : tmax[2*i+1];
                tmin[i] = (tmin[2*i] < tmin[2*i+1]) ? tmin[2*i] : tmin[2*i+1];
            end
        end
        a_top  = {tmax[0][DIFF_W-1], tmax[0]};
        b_neg  = -{tmin[0][DIFF_W-1], tmin[0]};
        thr    = {2'b00, r_thresh};
        corner = (a_top > thr) || (b_neg > thr);
        best   = (a_top > b_neg) ? a_top : b_neg;
        entry  = corner ? {1'b1, PIX_W'(best - 1'b1)} : '0;
    end

    always_comb begin
        keep = 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(i == 1 && j == 1) &&
                    !(r_dwin[1][1][PIX_W-1:0] > r_dwin[i][j][PIX_W-1:0])) begin
                    keep = 1'b0;
                end
            end
        end
        if (!r_suppress) begin
            keep = 1'b1;
        end
        res_score = r_suppress ? r_dwin[1][1][PIX_W-1:0] : '0;
        res_valid = en && r_s2_valid && r_s2_dec && r_dwin[1][1][PIX_W] && keep;
    end

    assign taken = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (taken) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (r_out_valid && !taken) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (taken) begin
                r_out_x     <= r_skid_x;
                r_out_y     <= r_skid_y;
                r_out_score <= r_skid_score;
            end
        end else if (res_valid) begin
            if (r_out_valid && !taken) begin
                r_skid_x     <= r_s2_x[OUT_W-1:0];
                r_skid_y     <= r_s2_y[OUT_W-1:0];
                r_skid_score <= res_score;
            end else begin
                r_out_x     <= r_s2_x[OUT_W-1:0];
                r_out_y     <= r_s2_y[OUT_W-1:0];
                r_out_score <= res_score;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_corner_x     = r_out_x;
    assign o_corner_y     = r_out_y;
    assign o_corner_score = r_out_score;

endmodule

// File: sv/fast9_ram.sv
// ----------------------------------------------------------------------------
// FAST-9 generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fast9_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: verif/tb_fast9_corner_detector.sv
// ----------------------------------------------------------------------------
// FAST-9 corner detector testbench
// Streams small grayscale frames through the detector under random idling and
// back-pressure. A cycle-free model of the line stores, the segment test, the
// score and the 3x3 suppression predicts every corner, and each output beat is
// checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_fast9_corner_detector;
    import fast9_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEM_TARGET = 650;

    typedef struct {
        int x;
        int y;
        int score;
    } corner_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [PIX_W-1:0] i_pixel_value = '0;
    logic             i_frame_start = 1'b0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [OUT_W-1:0] o_corner_x;
    logic [OUT_W-1:0] o_corner_y;
    logic [PIX_W-1:0] o_corner_score;

    fast9_corner_detector dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model state.
    logic [7:0] pix_rows [PIX_ROWS][MAX_WIDTH];
    logic [8:0] score_rows [SCORE_ROWS][MAX_WIDTH];
    int         col_cnt, row_cnt;
    bit         drain_armed;
    int         cfg_w, cfg_h, cfg_t, cfg_sup;

    corner_t    corner_q[$];
    int         errors = 0;
    int         cycles = 0;
    int         items_sent = 0;
    int         hold_left = 0;
    int         stall_left = 0;
    bit         no_idle = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_fast9_corner_detector: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int clamp_dim(input int v);
        if (v < 7) return 7;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return v;
    endfunction

    function automatic int imin(input int a, input int b);
        return a < b ? a : b;
    endfunction

    function automatic int imax(input int a, input int b);
        return a > b ? a : b;
    endfunction

    function automatic int fast9_score(input int p[CIRCLE_POINTS], input int v, input int t);
        int d[25];
        int a, b, a0, b0;
        for (int k = 0; k < 25; k++) d[k] = v - p[k & 15];
        a0 = t;
        for (int k = 0; k < 16; k += 2) begin
            a = imin(imin(d[k+1], d[k+2]), d[k+3]);
            if (a > a0) begin
                for (int n = 4; n <= 8; n++) a = imin(a, d[k+n]);
                a0 = imax(a0, imin(a, d[k]));
                a0 = imax(a0, imin(a, d[k+9]));
            end
        end
        b0 = -a0;
        for (int k = 0; k < 16; k += 2) begin
            b = imax(imax(d[k+1], d[k+2]), d[k+3]);
            b = imax(b, d[k+4]);
            b = imax(b, d[k+5]);
            if (b < b0) begin
                for (int n = 6; n <= 8; n++) b = imax(b, d[k+n]);
                b0 = imin(b0, imax(b, d[k]));
                b0 = imin(b0, imax(b, d[k+9]));
            end
        end
        return -b0 - 1;
    endfunction

    function automatic logic [8:0] centre_entry(input int r, input int c);
        int  p[CIRCLE_POINTS];
        int  v, s, q;
        bit  corner, dark, bright;
        v = pix_rows[(r - 3) % 7][c - 3];
        for (int k = 0; k < CIRCLE_POINTS; k++)
            p[k] = pix_rows[(r - 6 + CIRCLE_ROW[k]) % 7][c - 6 + CIRCLE_COL[k]];
        corner = 0;
        for (int st = 0; st < CIRCLE_POINTS; st++) begin
            dark = 1;
            bright = 1;
            for (int n = 0; n < ARC_LEN; n++) begin
                q = p[(st + n) & 15];
                if (!(q < v - cfg_t)) dark = 0;
                if (!(q > v + cfg_t)) bright = 0;
            end
            if (dark || bright) corner = 1;
        end
        if (!corner) return 9'd0;
        s = fast9_score(p, v, cfg_t);
        if (s < 0) s = 0;
        if (s > 255) s = 255;
        return {1'b1, 8'(s)};
    endfunction

    function automatic int nb_score(input int y, input int x, input int w, input int h);
        if (y < 3 || y > h - 4 || x < 3 || x > w - 4) return 0;
        return int'(score_rows[y & 3][x][7:0]);
    endfunction

    task automatic predict_pixel(input int pix, input bit fs);
        int      w, h, r, c, y, x, sc;
        bit      decide, keep;
        corner_t hit;
        w = clamp_dim(cfg_w);
        h = clamp_dim(cfg_h);
        decide = 0;
        y = 0;
        x = 0;
        if (fs) begin
            if (col_cnt != 0 || row_cnt != 0) drain_armed = 0;
            col_cnt = 0;
            row_cnt = 0;
        end else begin
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (row_cnt >= h) row_cnt = 0;
        end
        r = row_cnt;
        c = col_cnt;
        pix_rows[r % 7][c] = 8'(pix);
        if (r >= 6 && c >= 6 && c - 3 <= w - 4)
            score_rows[(r - 3) & 3][c - 3] = centre_entry(r, c);
        if (r >= 8) begin
            y = r - 5;
            x = c;
            decide = 1;
        end else if (drain_armed && r <= 1) begin
            y = h - 5 + r;
            x = c;
            decide = 1;
        end
        if (decide && y >= 3 && y <= h - 4 && x >= 3 && x <= w - 4 && score_rows[y & 3][x][8]) begin
            sc = int'(score_rows[y & 3][x][7:0]);
            keep = 1;
            if (cfg_sup != 0) begin
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if ((dy != 0 || dx != 0) && !(sc > nb_score(y + dy, x + dx, w, h)))
                            keep = 0;
            end else begin
                sc = 0;
            end
            if (keep) begin
                hit.x = x;
                hit.y = y;
                hit.score = sc;
                corner_q.push_back(hit);
            end
        end
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) begin
                row_cnt = 0;
                drain_armed = 1;
            end else if (row_cnt == 2) begin
                drain_armed = 0;
            end
        end
    endtask

    // Output side: checks every beat and draws a stall for the next one.
    always @(posedge i_clk) begin
        corner_t want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (corner_q.size() == 0) begin
                    report_mismatch("unexpected beat x", int'(o_corner_x), -1);
                end else begin
                    want = corner_q.pop_front();
                    if (int'(o_corner_x) != want.x) report_mismatch("x", o_corner_x, want.x);
                    if (int'(o_corner_y) != want.y) report_mismatch("y", o_corner_y, want.y);
                    if (int'(o_corner_score) != want.score)
                        report_mismatch("score", o_corner_score, want.score);
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0) stall_left--;
            i_stall <= (hold_left > 1) || (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    task automatic send_pixel(input int pix, input bit fs);
        int gap;
        i_valid <= 1'b1;
        i_pixel_value <= 8'(pix);
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_stall);
        predict_pixel(pix, fs);
        items_sent++;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (corner_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH:    cfg_w = val & 12'hFFF;
            CFG_HEIGHT:   cfg_h = val & 12'hFFF;
            CFG_THRESH:   cfg_t = val & 8'hFF;
            CFG_SUPPRESS: cfg_sup = val & 1;
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int w, input int h, input int t, input int sup);
        wait_idle();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_THRESH, t);
        cfg_write(CFG_SUPPRESS, sup);
    endtask

    function automatic int draw_pixel(input int style);
        case (style)
            0: return $urandom_range(0, 255);
            1: return ($urandom_range(0, 1) != 0) ? $urandom_range(200, 255) : $urandom_range(0, 40);
            default: begin
                if ($urandom_range(0, 19) == 0)
                    return ($urandom_range(0, 1) != 0) ? 255 : 0;
                return $urandom_range(90, 110);
            end
        endcase
    endfunction

    // Sends `count` pixels of a frame (count < 0 means the whole frame).
    task automatic send_frame(input int count, input int style);
        int total;
        total = clamp_dim(cfg_w) * clamp_dim(cfg_h);
        if (count < 0 || count > total) count = total;
        for (int n = 0; n < count; n++) send_pixel(draw_pixel(style), n == 0);
    endtask

    // Two more rows let the last band rows of a completed frame be decided.
    task automatic send_tail(input int style);
        for (int n = 0; n < 2 * clamp_dim(cfg_w); n++) send_pixel(draw_pixel(style), 1'b0);
    endtask

    task automatic test_smallest_frame();
        set_config(3, 0, 0, 1);
        send_frame(-1, 2);
        send_tail(2);
        set_config(7, 7, 255, 1);
        send_frame(-1, 1);
        send_tail(1);
    endtask

    task automatic test_no_suppression();
        set_config(12, 10, 10, 0);
        send_frame(-1, 2);
        send_tail(2);
    endtask

    task automatic test_widest_row();
        set_config(4095, 7, 15, 1);
        send_frame(-1, 2);
        send_tail(2);
    endtask

    task automatic test_frame_restart();
        set_config(10, 9, 12, 1);
        send_frame(-1, 2);
        send_frame(5, 2);
        send_frame(33, 1);
        send_frame(-1, 2);
        send_frame(-1, 2);
        send_tail(2);
    endtask

    task automatic test_back_pressure();
        set_config(14, 12, 8, 1);
        hold_left <= 400;
        no_idle = 1;
        send_frame(-1, 2);
        no_idle = 0;
        send_tail(2);
    endtask

    task automatic test_random_frames();
        int frames, t;
        while (items_sent < ITEM_TARGET + 20000) begin
            t = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 60);
            set_config($urandom_range(7, 20), $urandom_range(7, 14), t, $urandom_range(0, 1));
            no_idle = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++) begin
                if ($urandom_range(0, 3) == 0) send_frame($urandom_range(1, 60), $urandom_range(0, 2));
                send_frame(-1, $urandom_range(0, 2));
            end
            send_tail($urandom_range(0, 2));
            no_idle = 0;
            if (items_sent >= 20000 + ITEM_TARGET) break;
            if (items_sent < 20000) items_sent = 20000;
        end
    endtask

    initial begin
        cfg_w = 640;
        cfg_h = 480;
        cfg_t = 20;
        cfg_sup = 1;
        col_cnt = 0;
        row_cnt = 0;
        drain_armed = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_smallest_frame();
        test_no_suppression();
        test_widest_row();
        test_frame_restart();
        test_back_pressure();
        items_sent = 0;
        test_random_frames();
        wait_idle();
        if (errors == 0) begin
            $display("tb_fast9_corner_detector: clean");
        end else begin
            $display("tb_fast9_corner_detector: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/fast9_pkg.sv
sv/fast9_ram.sv
sv/fast9_corner_detector.sv
verif/tb_fast9_corner_detector.sv
